// ===== rtl/sit_pkg.sv =====
package sit_pkg;

  localparam int ENTRIES = 32;

  localparam int IDX_W   = 8;
  localparam int CNT_W   = 9;
  localparam int STAMP_W = 32;
  localparam int KEY_W   = 64;
  localparam int SLOT_W  = 5;
  localparam int USED_W  = 6;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [STAMP_W-1:0] STAMP_NONE = '1;
  localparam logic [CNT_W-1:0]   CNT_ONE    = 1;
  localparam logic [USED_W-1:0]  USED_MAX   = '1;

  typedef struct packed {
    logic [1:0]         operation;
    logic [KEY_W-1:0]   id_high;
    logic [KEY_W-1:0]   id_low;
    logic [STAMP_W-1:0] now_time;
  } sit_req_t;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic [USED_W-1:0]  used_count;
    logic [STAMP_W-1:0] oldest_time;
  } sit_res_t;

  // scan packet passed from cell to cell
  typedef struct packed {
    logic               found;
    logic [IDX_W-1:0]   midx;
    logic [STAMP_W-1:0] mstamp;
    logic [STAMP_W-1:0] least;
    logic [IDX_W-1:0]   vidx;
    logic [CNT_W-1:0]   cnt;
    logic [STAMP_W-1:0] min1;
    logic [STAMP_W-1:0] min2;
  } sit_pkt_t;

  typedef struct packed {
    logic               en;
    logic               clear;
    logic [IDX_W-1:0]   idx;
    logic [KEY_W-1:0]   id_high;
    logic [KEY_W-1:0]   id_low;
    logic [STAMP_W-1:0] stamp;
  } sit_wr_t;

  localparam sit_pkt_t PKT_INIT = '{
    found:  1'b0,
    midx:   '0,
    mstamp: '0,
    least:  STAMP_NONE,
    vidx:   '0,
    cnt:    '0,
    min1:   STAMP_NONE,
    min2:   STAMP_NONE
  };

  function automatic logic [STAMP_W-1:0] min_stamp(input logic [STAMP_W-1:0] a,
                                                   input logic [STAMP_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [STAMP_W-1:0] nz_stamp(input logic [STAMP_W-1:0] s);
    return (s != '0) ? s : STAMP_NONE;
  endfunction

endpackage

// ===== rtl/seen_id_table_oldest_replace.sv =====
// Table of ENTRIES 128-bit identifiers with 32-bit store times, cleared at reset
// (zero time = unused). One request gives one result; no new request is taken
// until the previous one is done. For add and lookup, a scan token walks the
// row of entry cells one cell per cycle, collecting the first match, the
// replacement victim and the occupancy figures, then the finish state writes
// back and loads the result register. A clear goes straight to the finish
// state. A waiting result holds the write-back until it is taken.
module seen_id_table_oldest_replace #(
  parameter int ENTRIES = sit_pkg::ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  sit_pkg::sit_req_t req,
  output logic              res_valid,
  input  logic              res_stall,
  output sit_pkg::sit_res_t res
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]                  state;
  logic                        start;
  logic                        accept;
  logic                        fin_go;
  sit_pkg::sit_req_t           cur;
  sit_pkg::sit_wr_t            wr;
  sit_pkg::sit_res_t           res_next;
  logic                        tok [ENTRIES+1];
  sit_pkg::sit_pkt_t           pkt [ENTRIES+1];
  sit_pkg::sit_pkt_t           fin;
  logic [sit_pkg::CNT_W-1:0]   used_full;
  logic [sit_pkg::STAMP_W-1:0] new_stamp;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign fin_go    = (state == ST_FINISH) && !(res_valid && res_stall);

  assign tok[0] = start;
  assign pkt[0] = sit_pkg::PKT_INIT;
  assign fin    = pkt[ENTRIES];

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      sit_cell #(.INDEX(g)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .cur     (cur),
        .wr      (wr),
        .tok_in  (tok[g]),
        .pkt_in  (pkt[g]),
        .tok_out (tok[g+1]),
        .pkt_out (pkt[g+1])
      );
    end
  endgenerate

  always_comb begin
    res_next = '{hit: 1'b0, slot: '0, used_count: '0, oldest_time: sit_pkg::STAMP_NONE};
    wr       = '{en: 1'b0, clear: 1'b0, idx: fin.midx, id_high: cur.id_high,
                 id_low: cur.id_low, stamp: cur.now_time};
    used_full = fin.cnt;
    new_stamp = cur.now_time;
    if (cur.operation == sit_pkg::OP_CLEAR) begin
      wr.clear = fin_go;
    end else if (fin.found) begin
      res_next.hit  = 1'b1;
      res_next.slot = sit_pkg::SLOT_W'(fin.midx);
      new_stamp     = (cur.operation == sit_pkg::OP_ADD) ? cur.now_time : fin.mstamp;
      used_full     = (new_stamp != '0) ? fin.cnt + sit_pkg::CNT_ONE : fin.cnt;
      res_next.oldest_time = sit_pkg::min_stamp(fin.min1, sit_pkg::nz_stamp(new_stamp));
      wr.en = fin_go && (cur.operation == sit_pkg::OP_ADD);
    end else if (cur.operation == sit_pkg::OP_ADD) begin
      res_next.slot = sit_pkg::SLOT_W'(fin.vidx);
      wr.idx        = fin.vidx;
      wr.en         = fin_go;
      // victim in use means it was the least time of a full table
      if (fin.least != '0) begin
        used_full = fin.cnt - sit_pkg::CNT_ONE;
        res_next.oldest_time = sit_pkg::min_stamp(fin.min2, sit_pkg::nz_stamp(cur.now_time));
      end else begin
        res_next.oldest_time = sit_pkg::min_stamp(fin.min1, sit_pkg::nz_stamp(cur.now_time));
      end
      if (cur.now_time != '0) begin
        used_full = used_full + sit_pkg::CNT_ONE;
      end
    end else begin
      res_next.oldest_time = fin.min1;
    end
    if (cur.operation == sit_pkg::OP_CLEAR) begin
      res_next.used_count = '0;
    end else if (used_full > sit_pkg::CNT_W'(sit_pkg::USED_MAX)) begin
      res_next.used_count = sit_pkg::USED_MAX;
    end else begin
      res_next.used_count = used_full[sit_pkg::USED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      start     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      start <= 1'b0;
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req.operation == sit_pkg::OP_CLEAR) begin
              state <= ST_FINISH;
            end else begin
              state <= ST_SCAN;
              start <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (tok[ENTRIES]) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (fin_go) begin
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= req;
    end
    if (fin_go) begin
      res <= res_next;
    end
  end

endmodule

// ===== rtl/sit_cell.sv =====
module sit_cell #(
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  sit_pkg::sit_req_t cur,
  input  sit_pkg::sit_wr_t  wr,
  input  logic              tok_in,
  input  sit_pkg::sit_pkt_t pkt_in,
  output logic              tok_out,
  output sit_pkg::sit_pkt_t pkt_out
);

  localparam logic [sit_pkg::IDX_W-1:0] MY_IDX = INDEX[sit_pkg::IDX_W-1:0];

  logic [sit_pkg::KEY_W-1:0]   key_high;
  logic [sit_pkg::KEY_W-1:0]   key_low;
  logic [sit_pkg::STAMP_W-1:0] stamp;
  sit_pkg::sit_pkt_t           pkt_next;
  logic                        first;

  assign first = (key_high == cur.id_high) && (key_low == cur.id_low) && !pkt_in.found;

  always_comb begin
    pkt_next = pkt_in;
    if (first) begin
      pkt_next.found  = 1'b1;
      pkt_next.midx   = MY_IDX;
      pkt_next.mstamp = stamp;
    end else if (stamp != '0) begin
      pkt_next.cnt = pkt_in.cnt + sit_pkg::CNT_ONE;
      if (stamp < pkt_in.min1) begin
        pkt_next.min1 = stamp;
        pkt_next.min2 = pkt_in.min1;
      end else if (stamp < pkt_in.min2) begin
        pkt_next.min2 = stamp;
      end
    end
    if (stamp <= pkt_in.least) begin
      pkt_next.least = stamp;
      pkt_next.vidx  = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out  <= 1'b0;
      key_high <= '0;
      key_low  <= '0;
      stamp    <= '0;
    end else begin
      tok_out <= tok_in;
      if (wr.clear) begin
        key_high <= '0;
        key_low  <= '0;
        stamp    <= '0;
      end else if (wr.en && (wr.idx == MY_IDX)) begin
        key_high <= wr.id_high;
        key_low  <= wr.id_low;
        stamp    <= wr.stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in) begin
      pkt_out <= pkt_next;
    end
  end

endmodule
